>>> rtl/core/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants for the small 16-bit machine execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

    localparam int WORD_W      = 16;
    localparam int INS_W       = 17;
    localparam int OP_W        = 5;
    localparam int FLD_W       = 4;
    localparam int PC_W        = 8;
    localparam int LEN_W       = 9;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    localparam int REG_COUNT_DEF = 16;
    localparam int DATA_WORDS    = 16;
    localparam int DM_AW         = $clog2(DATA_WORDS);

    localparam logic [LEN_W-1:0] LEN_RESET = 9'd64;

    // host commands
    localparam logic [CMD_W-1:0] CMD_EXEC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RD   = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] ST_EXEC    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HALT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_HOST    = 2'd3;

    // opcodes
    localparam logic [OP_W-1:0] OP_NOP  = 5'h00;
    localparam logic [OP_W-1:0] OP_LD   = 5'h01;
    localparam logic [OP_W-1:0] OP_ST   = 5'h02;
    localparam logic [OP_W-1:0] OP_ADD  = 5'h03;
    localparam logic [OP_W-1:0] OP_SUB  = 5'h04;
    localparam logic [OP_W-1:0] OP_AND  = 5'h05;
    localparam logic [OP_W-1:0] OP_OR   = 5'h06;
    localparam logic [OP_W-1:0] OP_XOR  = 5'h07;
    localparam logic [OP_W-1:0] OP_ADDS = 5'h08;
    localparam logic [OP_W-1:0] OP_SUBS = 5'h09;
    localparam logic [OP_W-1:0] OP_ANDS = 5'h0A;
    localparam logic [OP_W-1:0] OP_SL   = 5'h0B;
    localparam logic [OP_W-1:0] OP_SR   = 5'h0C;
    localparam logic [OP_W-1:0] OP_ADDI = 5'h0D;
    localparam logic [OP_W-1:0] OP_SUBI = 5'h0E;
    localparam logic [OP_W-1:0] OP_BR   = 5'h0F;
    localparam logic [OP_W-1:0] OP_BZ   = 5'h10;
    localparam logic [OP_W-1:0] OP_CBZ  = 5'h11;
    localparam logic [OP_W-1:0] OP_CBNZ = 5'h12;

    // effects of one item on the machine state
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                rf_we;
        logic [FLD_W-1:0]    rf_waddr;
        logic [WORD_W-1:0]   rf_wdata;
        logic                dm_we;
        logic [DM_AW-1:0]    dm_addr;
        logic [WORD_W-1:0]   dm_wdata;
        logic                pc_we;
        logic [LEN_W-1:0]    pc_next;
        logic                flags_we;
        logic                zf;
        logic                nf;
        logic                set_halt;
        logic [WORD_W-1:0]   read_value;
    } t_exec_res;

endpackage

`default_nettype wire

>>> rtl/core/tsc_if.sv
// ----------------------------------------------------------------------------
// tsc_in_if / tsc_out_if
// Valid/ready channels for instruction and host items and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_in_if;
    logic                                valid;
    logic                                ready;
    logic [tsc_pkg::CMD_W-1:0]           cmd;
    logic [tsc_pkg::INS_W-1:0]           instruction;
    logic [tsc_pkg::DM_AW-1:0]           mem_address;
    logic signed [tsc_pkg::WORD_W-1:0]   write_value;

    modport source (output valid, cmd, instruction, mem_address, write_value,
                    input ready);
    modport sink   (input valid, cmd, instruction, mem_address, write_value,
                    output ready);
endinterface

interface tsc_out_if;
    logic                                valid;
    logic                                ready;
    logic [tsc_pkg::STATUS_W-1:0]        status;
    logic [tsc_pkg::PC_W-1:0]            next_pc;
    logic signed [tsc_pkg::WORD_W-1:0]   read_value;
    logic                                zero_flag;
    logic                                negative_flag;

    modport source (output valid, status, next_pc, read_value, zero_flag,
                    negative_flag, input ready);
    modport sink   (input valid, status, next_pc, read_value, zero_flag,
                    negative_flag, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tiny_sixteen_bit_cpu_execute.sv
// ----------------------------------------------------------------------------
// tiny_sixteen_bit_cpu_execute
// Execute stage of a small 16-bit load/store machine with host data access.
// ----------------------------------------------------------------------------
// One item (instruction or host access) is taken every cycle unless the result
// register stalls. The input stage registers the item
// together with its register file and data memory reads, the execute stage
// applies all state changes and loads the result register. Reads are
// bypassed from the write made in the same cycle, so dependent instructions
// may follow each other directly. The result register is the only stall
// point; the input side keeps taking items while the output side is free.
// Register indexes at or above REG_COUNT read as zero and are never written.
`default_nettype none

module tiny_sixteen_bit_cpu_execute #(
    parameter int REG_COUNT = tsc_pkg::REG_COUNT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    tsc_in_if.sink                          i_in,
    tsc_out_if.source                       o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic [tsc_pkg::LEN_W-1:0]  i_cfg_wdata
);
    import tsc_pkg::*;

    localparam int             RIDX_W = $clog2(REG_COUNT);
    localparam logic [FLD_W:0] RC     = (FLD_W+1)'(REG_COUNT);

    // machine state
    logic [WORD_W-1:0] r_rf     [REG_COUNT];
    logic              r_rf_vld [REG_COUNT];
    logic [WORD_W-1:0] r_dm     [DATA_WORDS];
    logic              r_dm_vld [DATA_WORDS];
    logic [PC_W-1:0]   r_pc;
    logic              r_zf, r_nf, r_halted;
    logic [LEN_W-1:0]  r_len;

    // input stage
    logic              r_in_vld;
    logic [CMD_W-1:0]  r_cmd;
    logic [INS_W-1:0]  r_ins;
    logic [DM_AW-1:0]  r_mem_addr;
    logic [WORD_W-1:0] r_wv;
    logic [WORD_W-1:0] r_opa, r_opb, r_dmrd;

    // result stage
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_status;
    logic [PC_W-1:0]     r_next_pc;
    logic [WORD_W-1:0]   r_read_value;
    logic                r_out_zf, r_out_nf;

    t_exec_res        res;
    logic             out_take, exec_go, in_acc;
    logic             rf_wr, dm_wr;
    logic [RIDX_W-1:0] rf_widx;
    logic [FLD_W-1:0] ra_fld, rb_fld;
    logic [DM_AW-1:0] dm_raddr;
    logic             ra_ok, rb_ok, w_ok;
    logic [OP_W-1:0]  in_op;
    logic [PC_W-1:0]  n_pc;
    logic             n_zf, n_nf;

    assign out_take   = !r_out_vld || o_out.ready;
    assign exec_go    = r_in_vld && out_take;
    assign i_in.ready = !r_in_vld || exec_go;
    assign in_acc     = i_in.valid && i_in.ready;

    // read addresses of the incoming item
    assign in_op    = i_in.instruction[16:12];
    assign ra_fld   = (in_op inside {OP_CBZ, OP_CBNZ}) ? i_in.instruction[3:0]
                                                       : i_in.instruction[11:8];
    assign rb_fld   = i_in.instruction[7:4];
    assign dm_raddr = (i_in.cmd == CMD_EXEC) ? i_in.instruction[DM_AW-1:0]
                                             : i_in.mem_address;
    assign ra_ok    = ({1'b0, ra_fld} < RC);
    assign rb_ok    = ({1'b0, rb_fld} < RC);

    tsc_exec u_exec (
        .i_cmd      (r_cmd),
        .i_ins      (r_ins),
        .i_mem_addr (r_mem_addr),
        .i_wv       (r_wv),
        .i_opa      (r_opa),
        .i_opb      (r_opb),
        .i_dmrd     (r_dmrd),
        .i_pc       (r_pc),
        .i_zf       (r_zf),
        .i_nf       (r_nf),
        .i_halted   (r_halted),
        .i_len      (r_len),
        .o_res      (res)
    );

    assign w_ok    = ({1'b0, res.rf_waddr} < RC);
    assign rf_widx = res.rf_waddr[RIDX_W-1:0];
    assign rf_wr   = exec_go && res.rf_we && w_ok;
    assign dm_wr   = exec_go && res.dm_we;

    assign n_pc = res.pc_we ? res.pc_next[PC_W-1:0] : r_pc;
    assign n_zf = res.flags_we ? res.zf : r_zf;
    assign n_nf = res.flags_we ? res.nf : r_nf;

    // storage arrays
    always_ff @(posedge i_clk) begin
        if (rf_wr) begin
            r_rf[rf_widx] <= res.rf_wdata;
        end
        if (dm_wr) begin
            r_dm[res.dm_addr] <= res.dm_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) r_rf_vld[k] <= 1'b0;
            for (int k = 0; k < DATA_WORDS; k++) r_dm_vld[k] <= 1'b0;
        end else begin
            if (rf_wr) r_rf_vld[rf_widx] <= 1'b1;
            if (dm_wr) r_dm_vld[res.dm_addr] <= 1'b1;
        end
    end

    // input stage payload and operand reads, bypassing this cycle's write
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd      <= i_in.cmd;
            r_ins      <= i_in.instruction;
            r_mem_addr <= i_in.mem_address;
            r_wv       <= i_in.write_value;

            if (!ra_ok) begin
                r_opa <= '0;
            end else if (rf_wr && (res.rf_waddr == ra_fld)) begin
                r_opa <= res.rf_wdata;
            end else begin
                r_opa <= r_rf_vld[ra_fld[RIDX_W-1:0]] ? r_rf[ra_fld[RIDX_W-1:0]] : '0;
            end

            if (!rb_ok) begin
                r_opb <= '0;
            end else if (rf_wr && (res.rf_waddr == rb_fld)) begin
                r_opb <= res.rf_wdata;
            end else begin
                r_opb <= r_rf_vld[rb_fld[RIDX_W-1:0]] ? r_rf[rb_fld[RIDX_W-1:0]] : '0;
            end

            if (dm_wr && (res.dm_addr == dm_raddr)) begin
                r_dmrd <= res.dm_wdata;
            end else begin
                r_dmrd <= r_dm_vld[dm_raddr] ? r_dm[dm_raddr] : '0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pc      <= '0;
            r_zf      <= 1'b0;
            r_nf      <= 1'b0;
            r_halted  <= 1'b0;
            r_len     <= LEN_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (out_take) begin
                r_out_vld <= exec_go;
            end
            if (exec_go) begin
                r_pc     <= n_pc;
                r_zf     <= n_zf;
                r_nf     <= n_nf;
                r_halted <= r_halted | res.set_halt;
            end
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_status     <= res.status;
            r_next_pc    <= n_pc;
            r_read_value <= res.read_value;
            r_out_zf     <= n_zf;
            r_out_nf     <= n_nf;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.status        = r_status;
    assign o_out.next_pc       = r_next_pc;
    assign o_out.read_value    = r_read_value;
    assign o_out.zero_flag     = r_out_zf;
    assign o_out.negative_flag = r_out_nf;

    // only reset clears the halted mark
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted mark cleared without reset");

    a_halt_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && (res.status == ST_HALT)) |=> (r_halted && r_out_vld))
        else $error("halt result without halted machine");

    a_host_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && (r_cmd != CMD_EXEC)) |=> $stable(r_pc))
        else $error("host access moved the program counter");

endmodule

`default_nettype wire

>>> rtl/core/tsc_exec.sv
// ----------------------------------------------------------------------------
// tsc_exec
// Decode and ALU: works out every state change of one item from its operands.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_exec (
    input  wire logic [tsc_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [tsc_pkg::INS_W-1:0]  i_ins,
    input  wire logic [tsc_pkg::DM_AW-1:0]  i_mem_addr,
    input  wire logic [tsc_pkg::WORD_W-1:0] i_wv,
    input  wire logic [tsc_pkg::WORD_W-1:0] i_opa,
    input  wire logic [tsc_pkg::WORD_W-1:0] i_opb,
    input  wire logic [tsc_pkg::WORD_W-1:0] i_dmrd,
    input  wire logic [tsc_pkg::PC_W-1:0]   i_pc,
    input  wire logic                       i_zf,
    input  wire logic                       i_nf,
    input  wire logic                       i_halted,
    input  wire logic [tsc_pkg::LEN_W-1:0]  i_len,
    output tsc_pkg::t_exec_res              o_res
);
    import tsc_pkg::*;

    logic [OP_W-1:0]   op;
    logic [FLD_W-1:0]  f0, f1, f2;
    logic [WORD_W-1:0] alu;
    logic              taken;
    logic [PC_W-1:0]   target;

    assign op = i_ins[16:12];
    assign f0 = i_ins[3:0];
    assign f1 = i_ins[7:4];
    assign f2 = i_ins[11:8];

    always_comb begin
        o_res            = '0;
        o_res.status     = ST_EXEC;
        o_res.flags_we   = 1'b0;
        o_res.zf         = i_zf;
        o_res.nf         = i_nf;
        alu              = '0;
        taken            = 1'b0;
        target           = i_ins[7:0];

        case (i_cmd)
            CMD_EXEC: begin
                if (i_halted || ({1'b0, i_pc} >= i_len) || (i_ins == '0)) begin
                    o_res.status   = ST_HALT;
                    o_res.set_halt = 1'b1;
                end else if (op > OP_CBNZ) begin
                    o_res.status = ST_INVALID;
                end else begin
                    case (op)
                        OP_LD: begin
                            o_res.rf_we    = 1'b1;
                            o_res.rf_waddr = f1;
                            o_res.rf_wdata = i_dmrd;
                        end
                        OP_ST: begin
                            o_res.dm_we    = 1'b1;
                            o_res.dm_addr  = f0[DM_AW-1:0];
                            o_res.dm_wdata = i_opb;
                        end
                        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR,
                        OP_ADDS, OP_SUBS, OP_ANDS: begin
                            case (op)
                                OP_ADD, OP_ADDS: alu = i_opa + i_opb;
                                OP_SUB, OP_SUBS: alu = i_opa - i_opb;
                                OP_OR:           alu = i_opa | i_opb;
                                OP_XOR:          alu = i_opa ^ i_opb;
                                default:         alu = i_opa & i_opb;
                            endcase
                            o_res.rf_we    = 1'b1;
                            o_res.rf_waddr = f0;
                            o_res.rf_wdata = alu;
                            if (op inside {OP_ADDS, OP_SUBS, OP_ANDS}) begin
                                o_res.flags_we = 1'b1;
                                o_res.zf       = (alu == '0);
                                o_res.nf       = alu[WORD_W-1];
                            end
                        end
                        OP_SL, OP_SR, OP_ADDI, OP_SUBI: begin
                            case (op)
                                OP_SL:   alu = i_opb << f0;
                                OP_SR:   alu = WORD_W'($signed(i_opb) >>> f0);
                                OP_ADDI: alu = i_opb + {{(WORD_W-FLD_W){1'b0}}, f0};
                                default: alu = i_opb - {{(WORD_W-FLD_W){1'b0}}, f0};
                            endcase
                            o_res.rf_we    = 1'b1;
                            o_res.rf_waddr = f2;
                            o_res.rf_wdata = alu;
                        end
                        OP_BR: taken = 1'b1;
                        OP_BZ: taken = i_zf;
                        OP_CBZ: begin
                            taken  = (i_opa == '0);
                            target = i_ins[11:4];
                        end
                        OP_CBNZ: begin
                            taken  = (i_opa != '0);
                            target = i_ins[11:4];
                        end
                        default: ;  // other opcode-0 words: no operation
                    endcase
                    o_res.pc_we    = 1'b1;
                    o_res.pc_next  = taken ? {1'b0, target} : ({1'b0, i_pc} + 9'd1);
                    o_res.set_halt = (o_res.pc_next >= i_len);
                end
            end
            CMD_WR: begin
                o_res.status   = ST_HOST;
                o_res.dm_we    = 1'b1;
                o_res.dm_addr  = i_mem_addr;
                o_res.dm_wdata = i_wv;
            end
            CMD_RD: begin
                o_res.status     = ST_HOST;
                o_res.read_value = i_dmrd;
            end
            default: o_res.status = ST_INVALID;
        endcase
    end

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tiny_sixteen_bit_cpu_execute. A table of directed
// items runs first, then random instruction streams under several program
// lengths, then one randomly chosen way of halting the machine. Every result
// is checked field by field against its typed row or the bench's machine model.
// ----------------------------------------------------------------------------

module tb;

    import tsc_pkg::*;

    localparam int                 NREG           = REG_COUNT_DEF;
    localparam int                 WATCHDOG_LIMIT = 2000;
    localparam int                 PHASE_ITEMS    = 100;
    localparam logic [CMD_W-1:0]   CMD_BAD        = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PC_W-1:0]     next_pc;
        logic [WORD_W-1:0]   read_value;
        logic                zero_flag;
        logic                negative_flag;
    } result_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [INS_W-1:0]  ins;
        logic [DM_AW-1:0]  addr;
        logic [WORD_W-1:0] wdata;
        logic              typed;
        result_t           res;
    } stim_row_t;

    typedef enum int {
        HALT_WORD,
        HALT_STEP_END,
        HALT_BRANCH_END,
        HALT_LEN_LOWERED,
        HALT_LEN_ZERO
    } halt_cause_t;

    localparam result_t NO_RES = '0;
    localparam int      N_ROWS = 26;

    // Typed results hold only where the state is obvious right after reset.
    localparam stim_row_t DIRECTED[N_ROWS] = '{
        '{CMD_RD,   17'h0,                       4'd0,  16'h0,    1'b1,
          '{ST_HOST, 8'd0, 16'h0, 1'b0, 1'b0}},
        '{CMD_WR,   17'h0,                       4'd15, 16'h7FFF, 1'b1,
          '{ST_HOST, 8'd0, 16'h0, 1'b0, 1'b0}},
        '{CMD_WR,   17'h0,                       4'd0,  16'h8000, 1'b1,
          '{ST_HOST, 8'd0, 16'h0, 1'b0, 1'b0}},
        '{CMD_RD,   17'h0,                       4'd15, 16'h0,    1'b1,
          '{ST_HOST, 8'd0, 16'h7FFF, 1'b0, 1'b0}},
        '{CMD_EXEC, {OP_LD, 4'h0, 4'd1, 4'd15},  4'd0,  16'h0,    1'b1,
          '{ST_EXEC, 8'd1, 16'h0, 1'b0, 1'b0}},
        '{CMD_EXEC, 17'h1FFFF,                   4'd0,  16'h0,    1'b1,
          '{ST_INVALID, 8'd1, 16'h0, 1'b0, 1'b0}},
        '{CMD_BAD,  17'h1FFFF,                   4'd15, 16'hFFFF, 1'b1,
          '{ST_INVALID, 8'd1, 16'h0, 1'b0, 1'b0}},
        '{CMD_EXEC, {OP_LD, 4'hF, 4'd2, 4'd0},   4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_ADD, 4'd1, 4'd2, 4'd3},  4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_SUB, 4'd2, 4'd1, 4'd4},  4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_AND, 4'd1, 4'd2, 4'd5},  4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_OR, 4'd1, 4'd2, 4'd6},   4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_XOR, 4'd3, 4'd1, 4'd7},  4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_ADDS, 4'd3, 4'd4, 4'd8}, 4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_BZ, 4'h0, 8'd40},        4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_SUBS, 4'd2, 4'd0, 4'd9}, 4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_ANDS, 4'd1, 4'd15, 4'd10}, 4'd0, 16'h0,   1'b0, NO_RES},
        '{CMD_EXEC, {OP_SL, 4'd11, 4'd1, 4'd15}, 4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_SR, 4'd12, 4'd2, 4'd15}, 4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_ADDI, 4'd13, 4'd1, 4'd15}, 4'd0, 16'h0,   1'b0, NO_RES},
        '{CMD_EXEC, {OP_SUBI, 4'd14, 4'd0, 4'd15}, 4'd0, 16'h0,   1'b0, NO_RES},
        '{CMD_EXEC, {OP_ST, 4'h0, 4'd12, 4'd5},  4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_RD,   17'h0,                       4'd5,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_CBNZ, 8'd62, 4'd1},      4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_NOP, 12'hFFF},           4'd0,  16'h0,    1'b0, NO_RES},
        '{CMD_EXEC, {OP_CBZ, 8'd0, 4'd0},        4'd0,  16'h0,    1'b0, NO_RES}
    };

    logic             clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    tsc_in_if  in_ch();
    tsc_out_if out_ch();

    tiny_sixteen_bit_cpu_execute dut (
        .i_clk       (clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // machine model
    logic [WORD_W-1:0] reg_model [NREG];
    logic [WORD_W-1:0] mem_model [DATA_WORDS];
    logic [PC_W-1:0]   pc_model;
    logic              zero_model;
    logic              neg_model;
    logic              halted_model;
    logic [LEN_W-1:0]  length_cfg;

    result_t pending_results[$];
    int      mismatches;
    int      idle_cycles;
    bit      burst;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] reg_value(input logic [FLD_W-1:0] idx);
        if (int'(idx) >= NREG) begin
            return '0;
        end
        return reg_model[idx];
    endfunction

    function automatic void reg_store(input logic [FLD_W-1:0] idx,
                                      input logic [WORD_W-1:0] v);
        if (int'(idx) < NREG) begin
            reg_model[idx] = v;
        end
    endfunction

    function automatic logic [STATUS_W-1:0] exec_instruction(input logic [INS_W-1:0] ins);
        logic [OP_W-1:0]   op;
        logic [FLD_W-1:0]  f0;
        logic [FLD_W-1:0]  f1;
        logic [FLD_W-1:0]  f2;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] r;
        logic [LEN_W-1:0]  nxt;
        op = ins[16:12];
        f0 = ins[3:0];
        f1 = ins[7:4];
        f2 = ins[11:8];
        if (halted_model || {1'b0, pc_model} >= length_cfg || ins == '0) begin
            halted_model = 1'b1;
            return ST_HALT;
        end
        if (op > OP_CBNZ) begin
            return ST_INVALID;
        end
        a   = reg_value(f2);
        b   = reg_value(f1);
        nxt = {1'b0, pc_model} + 9'd1;
        case (op)
            OP_LD:   reg_store(f1, mem_model[f0]);
            OP_ST:   mem_model[f0] = reg_value(f1);
            OP_ADD:  reg_store(f0, a + b);
            OP_SUB:  reg_store(f0, a - b);
            OP_AND:  reg_store(f0, a & b);
            OP_OR:   reg_store(f0, a | b);
            OP_XOR:  reg_store(f0, a ^ b);
            OP_ADDS, OP_SUBS, OP_ANDS: begin
                if (op == OP_ADDS) begin
                    r = a + b;
                end else if (op == OP_SUBS) begin
                    r = a - b;
                end else begin
                    r = a & b;
                end
                reg_store(f0, r);
                zero_model = (r == '0);
                neg_model  = r[WORD_W-1];
            end
            OP_SL: begin
                r = b << f0;
                reg_store(f2, r);
            end
            OP_SR: begin
                r = $signed(b) >>> f0;
                reg_store(f2, r);
            end
            OP_ADDI: reg_store(f2, b + f0);
            OP_SUBI: reg_store(f2, b - f0);
            OP_BR:   nxt = {1'b0, ins[7:0]};
            OP_BZ: begin
                if (zero_model) begin
                    nxt = {1'b0, ins[7:0]};
                end
            end
            OP_CBZ: begin
                if (reg_value(f0) == '0) begin
                    nxt = {1'b0, ins[11:4]};
                end
            end
            OP_CBNZ: begin
                if (reg_value(f0) != '0) begin
                    nxt = {1'b0, ins[11:4]};
                end
            end
            default: ;
        endcase
        pc_model = nxt[PC_W-1:0];
        if (nxt >= length_cfg) begin
            halted_model = 1'b1;
        end
        return ST_EXEC;
    endfunction

    function automatic result_t run_machine(input logic [CMD_W-1:0] cmd,
                                            input logic [INS_W-1:0] ins,
                                            input logic [DM_AW-1:0] addr,
                                            input logic [WORD_W-1:0] wdata);
        result_t r;
        r = '0;
        case (cmd)
            CMD_EXEC: r.status = exec_instruction(ins);
            CMD_WR: begin
                mem_model[addr] = wdata;
                r.status        = ST_HOST;
            end
            CMD_RD: begin
                r.read_value = mem_model[addr];
                r.status     = ST_HOST;
            end
            default: r.status = ST_INVALID;
        endcase
        r.next_pc       = pc_model;
        r.zero_flag     = zero_model;
        r.negative_flag = neg_model;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [INS_W-1:0] ins,
                             input logic [DM_AW-1:0] addr, input logic [WORD_W-1:0] wdata,
                             input logic typed, input result_t typed_res);
        int      gap;
        result_t r;
        gap = burst ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.cmd         = cmd;
        in_ch.instruction = ins;
        in_ch.mem_address = addr;
        in_ch.write_value = wdata;
        in_ch.valid       = 1'b1;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        r = run_machine(cmd, ins, addr, wdata);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    // Write only with nothing in flight; let the pipeline settle before writing.
    task automatic set_length(input logic [LEN_W-1:0] value);
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we     = 1'b0;
        length_cfg = value;
    endtask

    // Keep the machine running: targets stay below the length, and a step that
    // would reach the length is replaced by a branch back.
    task automatic send_random();
        logic [CMD_W-1:0] cmd;
        logic [INS_W-1:0] ins;
        logic [OP_W-1:0]  op;
        logic [PC_W-1:0]  tmax;
        int               pick;
        tmax = (length_cfg > 9'd256) ? 8'hFF : 8'(length_cfg - 9'd1);
        ins  = 17'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            cmd = CMD_WR;
        end else if (pick < 20) begin
            cmd = CMD_RD;
        end else if (pick < 22) begin
            cmd = CMD_BAD;
        end else begin
            cmd = CMD_EXEC;
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            op = 5'($urandom_range(int'(OP_CBNZ) + 1, 31));
        end else if (pick < 7) begin
            op = OP_NOP;
        end else begin
            op = 5'($urandom_range(int'(OP_LD), int'(OP_CBNZ)));
        end
        ins[16:12] = op;
        if (op == OP_BR || op == OP_BZ) begin
            ins[7:0] = 8'($urandom_range(0, tmax));
        end else if (op == OP_CBZ || op == OP_CBNZ) begin
            ins[11:4] = 8'($urandom_range(0, tmax));
        end
        if ({1'b0, pc_model} + 9'd1 >= length_cfg) begin
            ins = {OP_BR, 4'($urandom), 8'($urandom_range(0, tmax))};
        end
        if (ins == '0) begin
            ins[0] = 1'b1;
        end
        send_item(cmd, ins, 4'($urandom), 16'($urandom), 1'b0, NO_RES);
    endtask

    task automatic halt_machine();
        halt_cause_t cause;
        int          target;
        cause = halt_cause_t'($urandom_range(0, 4));
        case (cause)
            HALT_WORD: send_item(CMD_EXEC, '0, 4'd3, 16'h1234, 1'b0, NO_RES);
            HALT_STEP_END: begin
                // 255 + 1 reaches a length of 256
                set_length(9'd256);
                send_item(CMD_EXEC, {OP_BR, 4'h0, 8'hFF}, 4'd0, 16'h0, 1'b0, NO_RES);
                send_item(CMD_EXEC, {OP_NOP, 12'h001}, 4'd0, 16'h0, 1'b0, NO_RES);
            end
            HALT_BRANCH_END: begin
                target = $urandom_range(1, 255);
                set_length(9'(target));
                target = $urandom_range(target, 255);
                send_item(CMD_EXEC, {OP_BR, 4'h0, 8'(target)}, 4'd0, 16'h0,
                          1'b0, NO_RES);
            end
            HALT_LEN_LOWERED: begin
                set_length(9'd300);
                send_item(CMD_EXEC, {OP_BR, 4'h0, 8'd40}, 4'd0, 16'h0, 1'b0, NO_RES);
                set_length(9'($urandom_range(0, 40)));
                send_item(CMD_EXEC, {OP_ADD, 4'd1, 4'd2, 4'd3}, 4'd0, 16'h0,
                          1'b0, NO_RES);
            end
            default: begin
                set_length(9'd0);
                send_item(CMD_EXEC, {OP_ADD, 4'd1, 4'd2, 4'd3}, 4'd0, 16'h0,
                          1'b0, NO_RES);
            end
        endcase
        // halted: execute items do nothing, host access still works
        repeat (6) begin
            send_item(CMD_EXEC, 17'($urandom), 4'($urandom), 16'($urandom), 1'b0, NO_RES);
        end
        send_item(CMD_WR, 17'h0, 4'd9, 16'hA5A5, 1'b0, NO_RES);
        send_item(CMD_RD, 17'h0, 4'd9, 16'h0, 1'b0, NO_RES);
        send_item(CMD_BAD, 17'h0, 4'd9, 16'h0, 1'b0, NO_RES);
        send_item(CMD_EXEC, 17'h1FFFF, 4'd0, 16'h0, 1'b0, NO_RES);
        set_length(9'd1);
        send_item(CMD_EXEC, {OP_BR, 12'h000}, 4'd0, 16'h0, 1'b0, NO_RES);
    endtask

    initial begin
        logic [LEN_W-1:0] lengths [6];
        lengths           = '{9'd511, 9'd300, 9'd256, 9'd1, 9'd2, 9'd3};
        lengths[5]        = 9'($urandom_range(3, 255));
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_EXEC;
        in_ch.instruction = '0;
        in_ch.mem_address = '0;
        in_ch.write_value = '0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        mismatches        = 0;
        burst             = 1'b0;
        reg_model         = '{default: '0};
        mem_model         = '{default: '0};
        pc_model          = '0;
        zero_model        = 1'b0;
        neg_model         = 1'b0;
        halted_model      = 1'b0;
        length_cfg        = LEN_RESET;
        repeat (9) @(negedge clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            send_item(DIRECTED[i].cmd, DIRECTED[i].ins, DIRECTED[i].addr,
                      DIRECTED[i].wdata, DIRECTED[i].typed, DIRECTED[i].res);
        end

        for (int p = 0; p < 6; p++) begin
            set_length(lengths[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    burst = ($urandom_range(0, 3) == 0);
                end
                send_random();
            end
            // park the counter at 0 so the next length cannot strand it
            send_item(CMD_EXEC, {OP_BR, 12'h000}, 4'd0, 16'h0, 1'b0, NO_RES);
        end
        burst = 1'b0;
        halt_machine();

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // result sink: draw a stall before each transfer outside bursts
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            stall = burst ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
        end
    end

    always @(posedge clk) begin
        result_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result status", 16'(out_ch.status), '0);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.status !== want.status) begin
                    report_mismatch("status", 16'(out_ch.status), 16'(want.status));
                end
                if (out_ch.next_pc !== want.next_pc) begin
                    report_mismatch("next_pc", 16'(out_ch.next_pc), 16'(want.next_pc));
                end
                if (out_ch.read_value !== want.read_value) begin
                    report_mismatch("read_value", out_ch.read_value, want.read_value);
                end
                if (out_ch.zero_flag !== want.zero_flag) begin
                    report_mismatch("zero_flag", 16'(out_ch.zero_flag),
                                    16'(want.zero_flag));
                end
                if (out_ch.negative_flag !== want.negative_flag) begin
                    report_mismatch("negative_flag", 16'(out_ch.negative_flag),
                                    16'(want.negative_flag));
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

endmodule
